### hdl/url_component_splitter_unit_defines.svh
// ----------------------------------------------------------------------------
// URL component splitter assertion macros
// Shared checks for the URL component splitter, written against clk and
// the active-low asynchronous reset arst_n of the module that uses them.
// ----------------------------------------------------------------------------
`ifndef URL_COMPONENT_SPLITTER_UNIT_DEFINES_SVH
`define URL_COMPONENT_SPLITTER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UCS_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ucs check failed");

// The consequent must hold in the cycle after the antecedent.
`define UCS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ucs check failed");

`endif

### hdl/ucs_pkg.sv
// ----------------------------------------------------------------------------
// URL component splitter package
// Character codes, separator mark indexes and component codes shared by the
// parser and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package ucs_pkg;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_HASH  = 8'h23;

	localparam int NUM_MARKS = 7;
	localparam int MK_SCHEME = 0;
	localparam int MK_COLON1 = 1;
	localparam int MK_AT     = 2;
	localparam int MK_COLON2 = 3;
	localparam int MK_SLASH  = 4;
	localparam int MK_QMARK  = 5;
	localparam int MK_HASH   = 6;

	localparam int NUM_COMP = 8;

	typedef enum logic [2:0] {
		COMP_SCHEME,
		COMP_USER,
		COMP_PASSWORD,
		COMP_HOST,
		COMP_PORT,
		COMP_PATH,
		COMP_QUERY,
		COMP_FRAGMENT
	} comp_id_t;

endpackage

`default_nettype wire

### hdl/ucs_parser.sv
// ----------------------------------------------------------------------------
// URL component splitter parser
// Tracks the character position, the parse phase and the positions of the
// first separators of each kind. The next-state values are exported so that
// the final character's marks are available in the cycle it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ucs_parser #(
	parameter int MAX_LEN       = 4096,
	parameter int SCHEME_WINDOW = 8,
	parameter int POS_W         = 13
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   step,
	input  wire logic [7:0]                             char_in,
	input  wire logic                                   is_last,
	output logic      [ucs_pkg::NUM_MARKS-1:0][POS_W-1:0] mark_pos,
	output logic      [ucs_pkg::NUM_MARKS-1:0]            mark_vld,
	output logic      [POS_W-1:0]                         length,
	output logic                                          overflow
);
	import ucs_pkg::*;

	typedef enum logic [2:0] {
		PH_SCHEME,
		PH_AUTH,
		PH_PATH,
		PH_QUERY,
		PH_FRAG,
		PH_FAIL
	} phase_t;

	phase_t                             phase_q, phase_d;
	logic [1:0]                         cnt_q, cnt_d, cnt_t;
	logic [POS_W-1:0]                   pos_q, pos_d;
	logic                               ovf_q, ovf_d;
	logic [NUM_MARKS-1:0][POS_W-1:0]    mpos_q, mpos_d;
	logic [NUM_MARKS-1:0]               mvld_q, mvld_d;

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		cnt_t   = cnt_q;
		pos_d   = pos_q;
		ovf_d   = ovf_q;
		mpos_d  = mpos_q;
		mvld_d  = mvld_q;
		if (pos_q == POS_W'(MAX_LEN)) begin
			ovf_d = 1'b1;
		end else begin
			pos_d = pos_q + 1'b1;
			case (phase_q)
				PH_SCHEME: begin
					if (char_in == CH_COLON) begin
						cnt_t = 2'd1;
					end else if (char_in == CH_SLASH && (cnt_q == 2'd1 || cnt_q == 2'd2)) begin
						cnt_t = cnt_q + 2'd1;
					end else begin
						cnt_t = 2'd0;
					end
					cnt_d = cnt_t;
					if (cnt_t == 2'd3 && 32'(pos_q) < 32'(SCHEME_WINDOW)) begin
						if (!mvld_q[MK_SCHEME]) begin
							mvld_d[MK_SCHEME] = 1'b1;
							mpos_d[MK_SCHEME] = pos_q - POS_W'(2);
						end
						cnt_d   = 2'd0;
						phase_d = PH_AUTH;
					end else if (32'(pos_q) + 32'd1 >= 32'(SCHEME_WINDOW)) begin
						phase_d = PH_FAIL;
					end
				end
				PH_AUTH: begin
					if (char_in == CH_SLASH) begin
						if (!mvld_q[MK_SLASH]) begin
							mvld_d[MK_SLASH] = 1'b1;
							mpos_d[MK_SLASH] = pos_q;
						end
						phase_d = PH_PATH;
					end else if (char_in == CH_COLON) begin
						if (!mvld_q[MK_COLON1]) begin
							mvld_d[MK_COLON1] = 1'b1;
							mpos_d[MK_COLON1] = pos_q;
						end
						if (mvld_q[MK_AT] && !mvld_q[MK_COLON2]) begin
							mvld_d[MK_COLON2] = 1'b1;
							mpos_d[MK_COLON2] = pos_q;
						end
					end else if (char_in == CH_AT) begin
						if (!mvld_q[MK_AT]) begin
							mvld_d[MK_AT] = 1'b1;
							mpos_d[MK_AT] = pos_q;
						end
					end
				end
				PH_PATH: begin
					if (char_in == CH_QMARK) begin
						if (!mvld_q[MK_QMARK]) begin
							mvld_d[MK_QMARK] = 1'b1;
							mpos_d[MK_QMARK] = pos_q;
						end
						phase_d = PH_QUERY;
					end else if (char_in == CH_HASH) begin
						if (!mvld_q[MK_HASH]) begin
							mvld_d[MK_HASH] = 1'b1;
							mpos_d[MK_HASH] = pos_q;
						end
						phase_d = PH_FRAG;
					end
				end
				PH_QUERY: begin
					if (char_in == CH_HASH) begin
						if (!mvld_q[MK_HASH]) begin
							mvld_d[MK_HASH] = 1'b1;
							mpos_d[MK_HASH] = pos_q;
						end
						phase_d = PH_FRAG;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign mark_pos = mpos_d;
	assign mark_vld = mvld_d;
	assign length   = pos_d;
	assign overflow = ovf_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SCHEME;
			cnt_q   <= 2'd0;
			pos_q   <= '0;
			ovf_q   <= 1'b0;
			mvld_q  <= '0;
		end else if (step) begin
			if (is_last) begin
				phase_q <= PH_SCHEME;
				cnt_q   <= 2'd0;
				pos_q   <= '0;
				ovf_q   <= 1'b0;
				mvld_q  <= '0;
			end else begin
				phase_q <= phase_d;
				cnt_q   <= cnt_d;
				pos_q   <= pos_d;
				ovf_q   <= ovf_d;
				mvld_q  <= mvld_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			mpos_q <= mpos_d;
		end
	end

endmodule

`default_nettype wire

### hdl/url_component_splitter_unit.sv
// ----------------------------------------------------------------------------
// URL component splitter
// The block takes one character per cycle unless it stalls its input, and
// returns eight component items, one per cycle while out_stall is low, after the character marked last.
// ----------------------------------------------------------------------------
// A URL enters one character per item. The block stalls its input only when
// a final character meets a full result bank. Each character passes through
// an input register and the compare logic in the parser. The final character also
// loads all eight component items into a result bank in that same cycle,
// and the bank then presents them one per cycle while out_stall is low,
// scheme first and fragment last, from the bank register after the input register. The bank
// holds one URL: a final character that arrives while the previous URL's
// items are still leaving waits until the last of them is taken, so URLs of
// eight characters or more stream at one character per cycle while the output
// does not stall, and the final character of a shorter URL waits for the bank.
`default_nettype none
`include "url_component_splitter_unit_defines.svh"

module url_component_splitter_unit #(
	parameter int MAX_LEN       = 4096,
	parameter int SCHEME_WINDOW = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [7:0]       char_in,
	input  wire logic             is_last_char,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output ucs_pkg::comp_id_t     component_id,
	output logic                  component_present,
	output logic      [11:0]      start_pos,
	output logic      [11:0]      end_pos,
	output logic                  url_valid,
	output logic                  last_of_run
);
	import ucs_pkg::*;

	localparam int POS_W = $clog2(MAX_LEN + 1);

	function automatic logic [11:0] lo12(input logic [POS_W-1:0] v);
		logic [POS_W+11:0] w;
		w = (POS_W + 12)'(v);
		return w[11:0];
	endfunction

	logic                            valid_s1;
	logic [7:0]                      char_s1;
	logic                            last_s1;
	logic                            proceed_s1;
	logic                            in_accept;
	logic                            out_accept;
	logic                            bank_load;

	logic [NUM_MARKS-1:0][POS_W-1:0] mp;
	logic [NUM_MARKS-1:0]            mv;
	logic [POS_W-1:0]                len;
	logic                            ovf;

	logic                            url_ok;
	logic [POS_W-1:0]                s_pos [NUM_COMP];
	logic [POS_W-1:0]                e_pos [NUM_COMP];
	logic [POS_W-1:0]                a_pos, ae_pos, hs_pos, hc_pos, at_pos, pe_pos;
	logic                            hc_ok, c1_ok;

	logic                            nxt_pres  [NUM_COMP];
	logic [11:0]                     nxt_start [NUM_COMP];
	logic [11:0]                     nxt_end   [NUM_COMP];

	logic                            full_q;
	comp_id_t                        idx_q;
	logic                            urlv_q;
	logic                            pres_q    [NUM_COMP];
	logic [11:0]                     start_q   [NUM_COMP];
	logic [11:0]                     end_q     [NUM_COMP];

	assign out_accept = full_q && !out_stall;
	assign proceed_s1 = valid_s1 &&
		!(last_s1 && full_q && !(out_accept && idx_q == COMP_FRAGMENT));
	assign in_stall   = valid_s1 && !proceed_s1;
	assign in_accept  = in_valid && !in_stall;
	assign bank_load  = proceed_s1 && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (proceed_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			char_s1 <= char_in;
			last_s1 <= is_last_char;
		end
	end

	ucs_parser #(
		.MAX_LEN       (MAX_LEN),
		.SCHEME_WINDOW (SCHEME_WINDOW),
		.POS_W         (POS_W)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (proceed_s1),
		.char_in  (char_s1),
		.is_last  (last_s1),
		.mark_pos (mp),
		.mark_vld (mv),
		.length   (len),
		.overflow (ovf)
	);

	always_comb begin
		url_ok = mv[MK_SCHEME] && !ovf;
		a_pos  = '0;
		ae_pos = '0;
		hs_pos = '0;
		hc_pos = '0;
		at_pos = '0;
		pe_pos = '0;
		hc_ok  = 1'b0;
		c1_ok  = 1'b0;
		for (int k = 0; k < NUM_COMP; k++) begin
			s_pos[k] = '0;
			e_pos[k] = '0;
		end
		if (url_ok) begin
			a_pos  = mp[MK_SCHEME] + POS_W'(3);
			ae_pos = mv[MK_SLASH] ? mp[MK_SLASH] : len;
			e_pos[COMP_SCHEME] = mp[MK_SCHEME];
			if (a_pos < ae_pos) begin
				hs_pos = a_pos;
				if (mv[MK_AT]) begin
					at_pos = mp[MK_AT];
					c1_ok  = mv[MK_COLON1] && (mp[MK_COLON1] < at_pos);
					s_pos[COMP_USER] = a_pos;
					e_pos[COMP_USER] = c1_ok ? mp[MK_COLON1] : at_pos;
					if (c1_ok) begin
						s_pos[COMP_PASSWORD] = mp[MK_COLON1] + 1'b1;
						e_pos[COMP_PASSWORD] = at_pos;
					end
					hs_pos = at_pos + 1'b1;
					hc_ok  = mv[MK_COLON2];
					hc_pos = mp[MK_COLON2];
				end else begin
					hc_ok  = mv[MK_COLON1];
					hc_pos = mp[MK_COLON1];
				end
				s_pos[COMP_HOST] = hs_pos;
				e_pos[COMP_HOST] = hc_ok ? hc_pos : ae_pos;
				if (hc_ok) begin
					s_pos[COMP_PORT] = hc_pos + 1'b1;
					e_pos[COMP_PORT] = ae_pos;
				end
			end
			if (mv[MK_SLASH]) begin
				pe_pos = mv[MK_QMARK] ? mp[MK_QMARK] :
					(mv[MK_HASH] ? mp[MK_HASH] : len);
				s_pos[COMP_PATH] = ae_pos + 1'b1;
				e_pos[COMP_PATH] = pe_pos;
				if (mv[MK_QMARK]) begin
					s_pos[COMP_QUERY] = mp[MK_QMARK] + 1'b1;
					e_pos[COMP_QUERY] = mv[MK_HASH] ? mp[MK_HASH] : len;
				end
				if (mv[MK_HASH]) begin
					s_pos[COMP_FRAGMENT] = mp[MK_HASH] + 1'b1;
					e_pos[COMP_FRAGMENT] = len;
				end
			end
		end
		for (int k = 0; k < NUM_COMP; k++) begin
			nxt_pres[k]  = url_ok && (s_pos[k] < e_pos[k]);
			nxt_start[k] = nxt_pres[k] ? lo12(s_pos[k]) : 12'd0;
			nxt_end[k]   = nxt_pres[k] ? lo12(e_pos[k]) : 12'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			idx_q  <= COMP_SCHEME;
		end else if (bank_load) begin
			full_q <= 1'b1;
			idx_q  <= COMP_SCHEME;
		end else if (out_accept) begin
			if (idx_q == COMP_FRAGMENT) begin
				full_q <= 1'b0;
			end
			idx_q <= comp_id_t'(idx_q + 3'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (bank_load) begin
			urlv_q <= url_ok;
			for (int k = 0; k < NUM_COMP; k++) begin
				pres_q[k]  <= nxt_pres[k];
				start_q[k] <= nxt_start[k];
				end_q[k]   <= nxt_end[k];
			end
		end
	end

	assign out_valid         = full_q;
	assign component_id      = idx_q;
	assign component_present = pres_q[idx_q];
	assign start_pos         = start_q[idx_q];
	assign end_pos           = end_q[idx_q];
	assign url_valid         = urlv_q;
	assign last_of_run       = (idx_q == COMP_FRAGMENT);

	`UCS_ASSERT_SAME(a_bank_free, bank_load, !full_q || (out_accept && idx_q == COMP_FRAGMENT))
	`UCS_ASSERT_NEXT(a_run_ends, out_accept && idx_q == COMP_FRAGMENT && !bank_load, !out_valid)
	`UCS_ASSERT_SAME(a_invalid_absent, out_valid && !url_valid, !component_present)
	`UCS_ASSERT_NEXT(a_run_starts, bank_load, out_valid && component_id == COMP_SCHEME)

endmodule

`default_nettype wire
